// ===== hdl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants for the Diophantine range counter.
// ----------------------------------------------------------------------------
package drc_pkg;

  // default coefficient / range width
  localparam int DATA_WIDTH_DEF = 32;

  // operation of the shared serial unit
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_t;

  // request from the sequencer to the serial unit
  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  // status back from the serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/drc_serial_unit.sv =====
// ----------------------------------------------------------------------------
// drc_serial_unit
// Shared bit-serial arithmetic unit: signed truncating divide (quotient and
// remainder, restoring, one bit per cycle) and signed shift-add multiply.
// ----------------------------------------------------------------------------
module drc_serial_unit #(
  parameter int DATA_WIDTH = drc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  drc_pkg::unit_req_t                  req,
  input  logic signed [2*DATA_WIDTH+3:0]      opa,
  input  logic signed [2*DATA_WIDTH+3:0]      opb,
  output drc_pkg::unit_stat_t                 stat,
  output logic signed [2*DATA_WIDTH+3:0]      res_q,
  output logic signed [2*DATA_WIDTH+3:0]      res_r
);

  localparam int IW        = 2*DATA_WIDTH+4;
  localparam int MUL_STEPS = DATA_WIDTH+2;
  localparam int CW        = $clog2(IW+1);

  drc_pkg::op_t       op_r;
  logic [IW-1:0]      acc_r;
  logic [IW-1:0]      sh_r;
  logic [IW-1:0]      den_r;
  logic               neg_q_r;
  logic               neg_r_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic signed [IW-1:0] res_q_r;
  logic signed [IW-1:0] res_r_r;

  logic [IW-1:0]      mag_a;
  logic [IW-1:0]      mag_b;
  logic [IW-1:0]      trial;
  logic [IW:0]        diff;

  // operand magnitudes
  assign mag_a = opa[IW-1] ? IW'(-opa) : IW'(opa);
  assign mag_b = opb[IW-1] ? IW'(-opb) : IW'(opb);

  // restoring divide step
  assign trial = {acc_r[IW-2:0], sh_r[IW-1]};
  assign diff  = {1'b0, trial} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= drc_pkg::OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        op_r   <= req.op;
        busy_r <= 1'b1;
        den_r  <= mag_b;
        acc_r  <= '0;
        if (req.op == drc_pkg::OP_DIV) begin
          sh_r    <= mag_a;
          neg_q_r <= opa[IW-1] ^ opb[IW-1];
          neg_r_r <= opa[IW-1];
          cnt_r   <= CW'(IW);
        end else begin
          sh_r    <= IW'(opa);
          neg_q_r <= opb[IW-1];
          neg_r_r <= 1'b0;
          cnt_r   <= CW'(MUL_STEPS);
        end
      end else if (busy_r && cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (op_r == drc_pkg::OP_DIV) begin
          if (!diff[IW]) begin
            acc_r <= diff[IW-1:0];
            sh_r  <= {sh_r[IW-2:0], 1'b1};
          end else begin
            acc_r <= trial;
            sh_r  <= {sh_r[IW-2:0], 1'b0};
          end
        end else begin
          if (den_r[0]) acc_r <= acc_r + sh_r;
          sh_r  <= {sh_r[IW-2:0], 1'b0};
          den_r <= {1'b0, den_r[IW-1:1]};
        end
      end else if (busy_r) begin
        // apply signs and hand the result back
        busy_r <= 1'b0;
        done_r <= 1'b1;
        if (op_r == drc_pkg::OP_DIV) begin
          res_q_r <= neg_q_r ? -$signed(sh_r) : $signed(sh_r);
          res_r_r <= neg_r_r ? -$signed(acc_r) : $signed(acc_r);
        end else begin
          res_q_r <= neg_q_r ? -$signed(acc_r) : $signed(acc_r);
          res_r_r <= '0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res_q     = res_q_r;
  assign res_r     = res_r_r;

  // no start is taken while an operation runs
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running operation");
  a_busy_clears: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("unit busy while reporting done");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(IW))
    else $error("step count out of range");

endmodule

// ===== hdl/diophantine_range_count.sv =====
// ----------------------------------------------------------------------------
// diophantine_range_count
// Counts the solutions of a*x + b*y = g (g from extended Euclid) whose x and
// y lie in the given closed ranges, and reports g and the Bezout pair.
// ----------------------------------------------------------------------------
// Pulse start while busy is low; the item is taken at that edge and busy
// stays high until the result. The result appears for exactly one cycle with
// out_valid high and busy already low, and cannot be held off. Every divide
// and multiply runs on one shared bit-serial unit. An item needs one divide
// and one multiply for each of N Euclid steps (N up to about 46 at 32 bits),
// plus seven divides and eight multiplies for the range clipping.
// A zero coefficient skips the clipping.
// ----------------------------------------------------------------------------
module diophantine_range_count #(
  parameter int DATA_WIDTH = drc_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_coef_a,
  input  logic signed [DATA_WIDTH-1:0] in_coef_b,
  input  logic signed [DATA_WIDTH-1:0] in_x_low,
  input  logic signed [DATA_WIDTH-1:0] in_x_high,
  input  logic signed [DATA_WIDTH-1:0] in_y_low,
  input  logic signed [DATA_WIDTH-1:0] in_y_high,
  output logic                         out_valid,
  output logic [DATA_WIDTH:0]          out_solution_count,
  output logic signed [DATA_WIDTH-1:0] out_divisor,
  output logic signed [DATA_WIDTH-1:0] out_bezout_x,
  output logic signed [DATA_WIDTH-1:0] out_bezout_y,
  output logic                         out_zero_coef_error
);

  localparam int IW        = 2*DATA_WIDTH+4;
  localparam int STK_DEPTH = 2*DATA_WIDTH;
  localparam int AW        = $clog2(STK_DEPTH);
  localparam int NW        = $clog2(STK_DEPTH+1);
  localparam int EXT       = IW-DATA_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_ETEST, S_EDIV, S_BACK, S_BRD, S_BMUL, S_RDA, S_RDB,
    S_KDIV, S_MB, S_MA, S_ADJ, S_CHK, S_FMIN, S_FCMP, S_FDIV
  } state_t;

  state_t state_r;
  logic   pend_r;
  logic [1:0] st_r;
  logic [NW-1:0] n_r;

  logic signed [IW-1:0] ain_r, bin_r, a_r, b_r, g_r;
  logic signed [IW-1:0] x_r, y_r, k_r;
  logic signed [IW-1:0] xl_r, xh_r, yl_r, yh_r;
  logic signed [IW-1:0] lx1_r, rx1_r, lx2_r, rx2_r, lo_r, hi_r;
  logic                 err_r;

  logic                         out_valid_r;
  logic [DATA_WIDTH:0]          cnt_out_r;
  logic signed [DATA_WIDTH-1:0] g_out_r, bx_out_r, by_out_r;
  logic                         err_out_r;

  // quotient stack of the Euclid pass
  logic signed [DATA_WIDTH:0] stk_mem [STK_DEPTH];
  logic signed [DATA_WIDTH:0] stk_rd_r;

  drc_pkg::unit_req_t  req;
  drc_pkg::unit_stat_t stat;
  logic signed [IW-1:0] opa, opb, res_q, res_r;

  logic signed [IW-1:0] abs_a, abs_b, sb_a, sa_b, l2, r2;
  logic                 is_op;

  drc_serial_unit #(.DATA_WIDTH(DATA_WIDTH)) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .stat  (stat),
    .res_q (res_q),
    .res_r (res_r)
  );

  // sign-dependent steps (a and b are nonzero when used)
  assign abs_a = a_r[IW-1] ? -a_r : a_r;
  assign abs_b = b_r[IW-1] ? -b_r : b_r;
  assign sb_a  = b_r[IW-1] ? -a_r : a_r;
  assign sa_b  = a_r[IW-1] ? -b_r : b_r;
  assign l2    = (rx2_r < lx2_r) ? rx2_r : lx2_r;
  assign r2    = (rx2_r < lx2_r) ? lx2_r : rx2_r;

  // operand selection for the shared unit
  always_comb begin
    opa     = '0;
    opb     = '0;
    req.op  = drc_pkg::OP_DIV;
    is_op   = 1'b1;
    unique case (state_r)
      S_EDIV: begin opa = a_r; opb = b_r; end
      S_BMUL: begin
        req.op = drc_pkg::OP_MUL;
        opa    = y_r;
        opb    = {{(IW-DATA_WIDTH-1){stk_rd_r[DATA_WIDTH]}}, stk_rd_r};
      end
      S_RDA:  begin opa = ain_r; opb = g_r; end
      S_RDB:  begin opa = bin_r; opb = g_r; end
      S_KDIV: begin
        case (st_r)
          2'd0:    begin opa = xl_r - x_r; opb = b_r; end
          2'd1:    begin opa = xh_r - x_r; opb = b_r; end
          2'd2:    begin opa = y_r - yl_r; opb = a_r; end
          default: begin opa = y_r - yh_r; opb = a_r; end
        endcase
      end
      S_MB:   begin req.op = drc_pkg::OP_MUL; opa = k_r; opb = b_r; end
      S_MA:   begin req.op = drc_pkg::OP_MUL; opa = k_r; opb = a_r; end
      S_FDIV: begin opa = hi_r - lo_r; opb = abs_b; end
      default: is_op = 1'b0;
    endcase
    req.start = is_op && !pend_r;
  end

  // quotient stack: push during Euclid, registered read during back pass
  always_ff @(posedge clk) begin
    if (state_r == S_EDIV && stat.done) begin
      stk_mem[n_r[AW-1:0]] <= res_q[DATA_WIDTH:0];
    end
    stk_rd_r <= stk_mem[n_r[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      st_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (req.start) pend_r <= 1'b1;
      if (stat.done) pend_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ain_r <= {{EXT{in_coef_a[DATA_WIDTH-1]}}, in_coef_a};
            bin_r <= {{EXT{in_coef_b[DATA_WIDTH-1]}}, in_coef_b};
            a_r   <= {{EXT{in_coef_a[DATA_WIDTH-1]}}, in_coef_a};
            b_r   <= {{EXT{in_coef_b[DATA_WIDTH-1]}}, in_coef_b};
            xl_r  <= {{EXT{in_x_low[DATA_WIDTH-1]}}, in_x_low};
            xh_r  <= {{EXT{in_x_high[DATA_WIDTH-1]}}, in_x_high};
            yl_r  <= {{EXT{in_y_low[DATA_WIDTH-1]}}, in_y_low};
            yh_r  <= {{EXT{in_y_high[DATA_WIDTH-1]}}, in_y_high};
            err_r <= (in_coef_a == '0) || (in_coef_b == '0);
            n_r   <= '0;
            state_r <= S_ETEST;
          end
        end
        // Euclid forward pass
        S_ETEST: begin
          if (b_r == '0) begin
            x_r     <= IW'(1);
            y_r     <= '0;
            g_r     <= a_r;
            state_r <= S_BACK;
          end else begin
            state_r <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (stat.done) begin
            n_r     <= n_r + NW'(1);
            a_r     <= b_r;
            b_r     <= res_r;
            state_r <= S_ETEST;
          end
        end
        // back substitution for the Bezout pair
        S_BACK: begin
          if (n_r == '0) begin
            g_out_r  <= g_r[DATA_WIDTH-1:0];
            bx_out_r <= x_r[DATA_WIDTH-1:0];
            by_out_r <= y_r[DATA_WIDTH-1:0];
            if (err_r) begin
              cnt_out_r   <= '0;
              err_out_r   <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_RDA;
            end
          end else begin
            n_r     <= n_r - NW'(1);
            state_r <= S_BRD;
          end
        end
        S_BRD: state_r <= S_BMUL;
        S_BMUL: begin
          if (stat.done) begin
            x_r     <= y_r;
            y_r     <= x_r - res_q;
            state_r <= S_BACK;
          end
        end
        // reduce a and b by g
        S_RDA: begin
          if (stat.done) begin
            a_r     <= res_q;
            state_r <= S_RDB;
          end
        end
        S_RDB: begin
          if (stat.done) begin
            b_r     <= res_q;
            st_r    <= '0;
            state_r <= S_KDIV;
          end
        end
        // clip along the solution line
        S_KDIV: begin
          if (stat.done) begin
            k_r     <= res_q;
            state_r <= S_MB;
          end
        end
        S_MB: begin
          if (stat.done) begin
            x_r     <= x_r + res_q;
            state_r <= S_MA;
          end
        end
        S_MA: begin
          if (stat.done) begin
            y_r     <= y_r - res_q;
            state_r <= S_ADJ;
          end
        end
        S_ADJ: begin
          case (st_r)
            2'd0: if (x_r < xl_r) begin x_r <= x_r + abs_b; y_r <= y_r - sb_a; end
            2'd1: if (x_r > xh_r) begin x_r <= x_r - abs_b; y_r <= y_r + sb_a; end
            2'd2: if (y_r < yl_r) begin x_r <= x_r - sa_b; y_r <= y_r + abs_a; end
            default: if (y_r > yh_r) begin x_r <= x_r + sa_b; y_r <= y_r - abs_a; end
          endcase
          state_r <= S_CHK;
        end
        S_CHK: begin
          st_r    <= st_r + 2'd1;
          state_r <= S_KDIV;
          case (st_r)
            2'd0: begin
              lx1_r <= x_r;
              if (x_r > xh_r) begin
                cnt_out_r   <= '0;
                err_out_r   <= 1'b0;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
            2'd1: rx1_r <= x_r;
            2'd2: begin
              lx2_r <= x_r;
              if (y_r > yh_r) begin
                cnt_out_r   <= '0;
                err_out_r   <= 1'b0;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
            default: begin
              rx2_r   <= x_r;
              state_r <= S_FMIN;
            end
          endcase
        end
        // intersect the two x intervals
        S_FMIN: begin
          lo_r    <= (lx1_r > l2) ? lx1_r : l2;
          hi_r    <= (rx1_r < r2) ? rx1_r : r2;
          state_r <= S_FCMP;
        end
        S_FCMP: begin
          if (lo_r > hi_r) begin
            cnt_out_r   <= '0;
            err_out_r   <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (stat.done) begin
            cnt_out_r   <= res_q[DATA_WIDTH:0] + (DATA_WIDTH+1)'(1);
            err_out_r   <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_solution_count  = cnt_out_r;
  assign out_divisor         = g_out_r;
  assign out_bezout_x        = bx_out_r;
  assign out_bezout_y        = by_out_r;
  assign out_zero_coef_error = err_out_r;

  // checks
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result shown while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_out_r) |-> (cnt_out_r == '0))
    else $error("nonzero count with zero coefficient");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(STK_DEPTH))
    else $error("quotient stack overflow");
  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> pend_r)
    else $error("unit result with no request pending");

endmodule

// ===== bench/drc_checker.sv =====
// ----------------------------------------------------------------------------
// drc_checker
// Watches the item and result channels of the Diophantine range counter,
// predicts each result from the accepted item and compares field by field.
// ----------------------------------------------------------------------------
module drc_checker #(
  parameter int DATA_WIDTH = drc_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_coef_a,
  input  logic signed [DATA_WIDTH-1:0] in_coef_b,
  input  logic signed [DATA_WIDTH-1:0] in_x_low,
  input  logic signed [DATA_WIDTH-1:0] in_x_high,
  input  logic signed [DATA_WIDTH-1:0] in_y_low,
  input  logic signed [DATA_WIDTH-1:0] in_y_high,
  input  logic                         out_valid,
  input  logic [DATA_WIDTH:0]          out_solution_count,
  input  logic signed [DATA_WIDTH-1:0] out_divisor,
  input  logic signed [DATA_WIDTH-1:0] out_bezout_x,
  input  logic signed [DATA_WIDTH-1:0] out_bezout_y,
  input  logic                         out_zero_coef_error,
  output int                           fail_count,
  output int                           pending,
  output int                           result_count,
  output int                           nonzero_count
);

  typedef struct packed {
    logic [DATA_WIDTH:0]          count;
    logic signed [DATA_WIDTH-1:0] g;
    logic signed [DATA_WIDTH-1:0] bx;
    logic signed [DATA_WIDTH-1:0] by;
    logic                         err;
  } solution_t;

  solution_t expected_q[$];

  // extended Euclid with truncating division; returns g, Bezout pair via outputs
  function automatic longint euclid_gcd(longint a, longint b,
                                        output longint bx, output longint by);
    longint quot[128];
    int     n;
    longint x, y, t, r;
    n = 0;
    x = 1;
    y = 0;
    while (b != 0 && n < 128) begin
      r = a % b;
      quot[n] = a / b;
      n++;
      a = b;
      b = r;
    end
    while (n > 0) begin
      n--;
      t = y;
      y = x - quot[n] * y;
      x = t;
    end
    bx = x;
    by = y;
    return a;
  endfunction

  // clip the base solution to both ranges and count what is left
  function automatic longint range_count(longint a, longint b, longint g,
                                         longint x, longint y,
                                         longint xl, longint xh,
                                         longint yl, longint yh);
    longint sa, sb, k, lx1, rx1, lx2, rx2, lo, hi, ab, t;
    a = a / g;
    b = b / g;
    sa = (a > 0) ? 1 : -1;
    sb = (b > 0) ? 1 : -1;

    k = (xl - x) / b; x += k * b; y -= k * a;
    if (x < xl) begin x += sb * b; y -= sb * a; end
    if (x > xh) return 0;
    lx1 = x;

    k = (xh - x) / b; x += k * b; y -= k * a;
    if (x > xh) begin x -= sb * b; y += sb * a; end
    rx1 = x;

    k = (-(yl - y)) / a; x += k * b; y -= k * a;
    if (y < yl) begin x -= sa * b; y += sa * a; end
    if (y > yh) return 0;
    lx2 = x;

    k = (-(yh - y)) / a; x += k * b; y -= k * a;
    if (y > yh) begin x += sa * b; y -= sa * a; end
    rx2 = x;

    if (rx2 < lx2) begin t = rx2; rx2 = lx2; lx2 = t; end
    lo = (lx1 > lx2) ? lx1 : lx2;
    hi = (rx1 < rx2) ? rx1 : rx2;
    if (lo > hi) return 0;
    ab = (b < 0) ? -b : b;
    return (hi - lo) / ab + 1;
  endfunction

  function automatic solution_t predict_solution();
    solution_t s;
    longint    a, b, g, bx, by, cnt;
    a = in_coef_a;
    b = in_coef_b;
    g = euclid_gcd(a, b, bx, by);
    s.err = (a == 0 || b == 0);
    cnt = 0;
    if (!s.err) begin
      cnt = range_count(a, b, g, bx, by, longint'(in_x_low), longint'(in_x_high),
                        longint'(in_y_low), longint'(in_y_high));
    end
    s.count = cnt[DATA_WIDTH:0];
    s.g = g[DATA_WIDTH-1:0];
    s.bx = bx[DATA_WIDTH-1:0];
    s.by = by[DATA_WIDTH-1:0];
    return s;
  endfunction

  assign pending = expected_q.size();

  // take items and compare results at the rising edge
  always @(posedge clk) begin
    solution_t want;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      nonzero_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          result_count <= result_count + 1;
          if (want.count != 0) nonzero_count <= nonzero_count + 1;
          if (out_solution_count !== want.count || out_divisor !== want.g ||
              out_bezout_x !== want.bx || out_bezout_y !== want.by ||
              out_zero_coef_error !== want.err) begin
            fail_count <= fail_count + 1;
            if (out_solution_count !== want.count)
              $error("solution_count: expected %0d, got %0d", want.count,
                     out_solution_count);
            if (out_divisor !== want.g)
              $error("divisor: expected %0d, got %0d", want.g, out_divisor);
            if (out_bezout_x !== want.bx)
              $error("bezout_x: expected %0d, got %0d", want.bx, out_bezout_x);
            if (out_bezout_y !== want.by)
              $error("bezout_y: expected %0d, got %0d", want.by, out_bezout_y);
            if (out_zero_coef_error !== want.err)
              $error("zero_coef_error: expected %0b, got %0b", want.err,
                     out_zero_coef_error);
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_solution());
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random items into the Diophantine range counter under
// several sender idle rates and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  W         = drc_pkg::DATA_WIDTH_DEF;
  localparam int  N_RANDOM  = 300;
  localparam longint LIMIT  = 20_000_000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic signed [W-1:0] coef_a, coef_b, x_low, x_high, y_low, y_high;
  logic                out_valid;
  logic [W:0]          out_solution_count;
  logic signed [W-1:0] out_divisor, out_bezout_x, out_bezout_y;
  logic                out_zero_coef_error;
  int                  fail_count, pending, result_count, nonzero_count;
  int                  idle_pct;
  longint              cycles;

  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  diophantine_range_count #(.DATA_WIDTH(W)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(coef_a), .in_coef_b(coef_b),
    .in_x_low(x_low), .in_x_high(x_high), .in_y_low(y_low), .in_y_high(y_high),
    .out_valid(out_valid), .out_solution_count(out_solution_count),
    .out_divisor(out_divisor), .out_bezout_x(out_bezout_x),
    .out_bezout_y(out_bezout_y), .out_zero_coef_error(out_zero_coef_error)
  );

  drc_checker #(.DATA_WIDTH(W)) i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(coef_a), .in_coef_b(coef_b),
    .in_x_low(x_low), .in_x_high(x_high), .in_y_low(y_low), .in_y_high(y_high),
    .out_valid(out_valid), .out_solution_count(out_solution_count),
    .out_divisor(out_divisor), .out_bezout_x(out_bezout_x),
    .out_bezout_y(out_bezout_y), .out_zero_coef_error(out_zero_coef_error),
    .fail_count(fail_count), .pending(pending), .result_count(result_count),
    .nonzero_count(nonzero_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one item at a falling edge once busy is low and the sender is not idle
  task automatic send_item(input logic signed [W-1:0] a, b, xl, xh, yl, yh);
    @(negedge clk);
    while (busy || ($urandom_range(99) < idle_pct)) begin
      start = 1'b0;
      @(negedge clk);
    end
    coef_a = a; coef_b = b;
    x_low = xl; x_high = xh; y_low = yl; y_high = yh;
    start = 1'b1;
  endtask

  function automatic logic signed [W-1:0] rnd_small(int span);
    return $signed(W'($urandom_range(2 * span))) - span;
  endfunction

  // one random item: mostly small coefficients with windows that hold solutions
  task automatic send_random();
    logic signed [W-1:0] a, b, xl, xh, yl, yh;
    int mode;
    mode = $urandom_range(9);
    a = rnd_small(60);
    b = rnd_small(60);
    xl = rnd_small(500);
    xh = xl + $urandom_range(400) - 40;
    yl = rnd_small(500);
    yh = yl + $urandom_range(400) - 40;
    case (mode)
      0: begin
        a = $urandom; b = $urandom;
        xl = $urandom; xh = $urandom; yl = $urandom; yh = $urandom;
      end
      1: begin
        a = $urandom; b = $urandom;
      end
      2: begin
        xl = SMIN; xh = SMAX; yl = SMIN; yh = SMAX;
        a = rnd_small(4); b = rnd_small(4);
      end
      3: begin
        if ($urandom_range(1)) a = '0; else b = '0;
      end
      4: begin
        a = rnd_small(100000); b = rnd_small(100000);
        xl = rnd_small(1000000); xh = xl + $urandom_range(2000000);
        yl = rnd_small(1000000); yh = yl + $urandom_range(2000000);
      end
      default: begin
      end
    endcase
    send_item(a, b, xl, xh, yl, yh);
  endtask

  initial begin
    cycles = 0;
    start = 1'b0;
    coef_a = '0; coef_b = '0;
    x_low = '0; x_high = '0; y_low = '0; y_high = '0;
    idle_pct = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero coefficients, extremes, empty ranges, signs
    send_item(0, 7, -10, 10, -10, 10);
    send_item(7, 0, -10, 10, -10, 10);
    send_item(0, 0, -10, 10, -10, 10);
    send_item(SMIN, -1, SMIN, SMAX, SMIN, SMAX);
    send_item(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX);
    send_item(SMAX, SMAX, SMIN, SMAX, SMIN, SMAX);
    send_item(SMIN, SMIN, SMIN, SMAX, SMIN, SMAX);
    send_item(1, -1, SMIN, SMAX, SMIN, SMAX);
    send_item(1, 1, SMIN, SMAX, SMIN, SMAX);
    send_item(-1, -1, -5, 5, -5, 5);
    send_item(3, 5, 10, -10, -100, 100);
    send_item(3, 5, -100, 100, 10, -10);
    send_item(6, 10, 1, 1, -100, 100);
    send_item(6, -10, -100, 100, 1000, 1000);
    send_item(-12, 18, -50, 50, -50, 50);
    send_item(1836311903, 1134903170, SMIN, SMAX, SMIN, SMAX);
    send_item(-1836311903, 1134903170, -1000, 1000, SMIN, SMAX);
    send_item(SMAX, 1, 0, 0, SMIN, SMAX);
    send_item(SMIN, 1, SMIN, SMAX, 5, 5);
    send_item(SMAX, -2, -3, 3, -3, 3);

    // hold off until the directed part has drained
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);

    // random items over idle phases, including a stretch with no idling
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 63;
        2: idle_pct = 33;
        default: idle_pct = (i % 40 < 20) ? 0 : 63;
      endcase
      send_random();
    end
    @(negedge clk);
    start = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d results, %0d with a nonzero count, in %0d cycles",
             result_count, nonzero_count, cycles);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
